// ===== rtl/core/tpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants, register indexes and the tick control group for the
// trajectory tracking controller.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int PHASE_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 23;
	localparam int NKNOT_W    = 7;
	localparam int FRAC_W     = 17;
	localparam int FRAC_SHIFT = 16;
	localparam int PD_SHIFT   = 8;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_KNOTS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_TICKS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_THETA  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT = 3'd6;

	localparam logic [NKNOT_W-1:0] RST_NUM_KNOTS    = 7'd64;
	localparam logic [PHASE_W-1:0] RST_TICKS_PER    = 16'd10;
	localparam logic [PHASE_W-1:0] RST_INV_TICKS    = 16'd6554;
	localparam logic [GAIN_W-1:0]  RST_POS_GAIN     = 16'd2560;
	localparam logic [GAIN_W-1:0]  RST_VEL_GAIN     = 16'd256;
	localparam logic [CFG_W-1:0]   RST_FINAL_THETA  = 24'd12868;
	localparam logic [LIMIT_W-1:0] RST_TORQUE_LIMIT = 23'd180716;

	typedef struct packed {
		logic               valid;
		logic               finished;
		logic               last;
		logic [PHASE_W-1:0] phase;
	} tpc_tick_t;

endpackage

// ===== rtl/core/tpc_knot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_knot_mem
// Knot store: one write port, two registered read ports. Each word packs
// position, velocity and torque.
// ----------------------------------------------------------------------------
module tpc_knot_mem #(
	parameter int DEPTH  = 64,
	parameter int WORD_W = 72
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WORD_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WORD_W-1:0]        rd_data_a,
	output logic [WORD_W-1:0]        rd_data_b
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== rtl/core/tpc_timebase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_timebase
// Segment, phase and end-of-trajectory state; advances once per tick and
// forms the knot read addresses from the advanced time.
// ----------------------------------------------------------------------------
module tpc_timebase
	import tpc_pkg::*;
#(
	parameter int MAX_KNOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [NKNOT_W-1:0]           num_knots,
	input  logic [PHASE_W-1:0]           ticks_per_knot,
	output logic [$clog2(MAX_KNOTS)-1:0] rd_addr_a,
	output logic [$clog2(MAX_KNOTS)-1:0] rd_addr_b,
	output tpc_tick_t                    tick
);

	localparam int AW = $clog2(MAX_KNOTS);
	localparam int SW = $clog2(MAX_KNOTS + 1);
	localparam int CW = (SW > NKNOT_W) ? SW : NKNOT_W;

	logic [SW-1:0]      seg_q, seg_d, n_eff, idx;
	logic [PHASE_W-1:0] phase_q, phase_d, tpk_eff;
	logic [PHASE_W:0]   phase_inc;
	logic               fin_q, fin_d, seg_ge_n, last, last_s1, valid_s1;

	assign n_eff     = (CW'(num_knots) > CW'(MAX_KNOTS)) ? SW'(MAX_KNOTS) : SW'(num_knots);
	assign tpk_eff   = (ticks_per_knot == '0) ? PHASE_W'(1) : ticks_per_knot;
	assign phase_inc = {1'b0, phase_q} + (PHASE_W+1)'(1);
	assign seg_ge_n  = (seg_q >= n_eff);

	always_comb begin
		seg_d   = seg_q;
		phase_d = phase_q;
		fin_d   = fin_q;
		if (!fin_q) begin
			if (phase_inc >= {1'b0, tpk_eff}) begin
				if (seg_ge_n) begin
					fin_d = 1'b1;
				end else begin
					seg_d   = SW'(seg_q + 1'b1);
					phase_d = '0;
				end
			end else begin
				phase_d = phase_inc[PHASE_W-1:0];
				if (seg_ge_n) begin
					fin_d = 1'b1;
				end
			end
		end
	end

	assign idx       = (seg_d >= n_eff) ? SW'(n_eff - 1'b1) : seg_d;
	assign last      = (({1'b0, seg_d} + (SW+1)'(1)) >= {1'b0, n_eff});
	assign rd_addr_a = idx[AW-1:0];
	assign rd_addr_b = last ? idx[AW-1:0] : AW'(idx + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q    <= '0;
			phase_q  <= '0;
			fin_q    <= 1'b0;
			last_s1  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= go;
			if (go) begin
				seg_q   <= seg_d;
				phase_q <= phase_d;
				fin_q   <= fin_d;
				last_s1 <= last;
			end
		end
	end

	assign tick.valid    = valid_s1;
	assign tick.finished = fin_q;
	assign tick.last     = last_s1;
	assign tick.phase    = phase_q;

endmodule

// ===== rtl/core/tpc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_datapath
// Interpolation fraction, knot interpolation, PD terms, saturation and the
// output word register.
// ----------------------------------------------------------------------------
module tpc_datapath
	import tpc_pkg::*;
#(
	parameter int DATA_WIDTH = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tpc_tick_t                    tick,
	input  logic [3*DATA_WIDTH-1:0]      rd_data_a,
	input  logic [3*DATA_WIDTH-1:0]      rd_data_b,
	input  logic [PHASE_W-1:0]           inv_ticks_per_knot,
	input  logic [GAIN_W-1:0]            pos_gain,
	input  logic [GAIN_W-1:0]            vel_gain,
	input  logic signed [CFG_W-1:0]      final_theta,
	input  logic [LIMIT_W-1:0]           torque_limit,
	input  logic signed [DATA_WIDTH-1:0] meas_pos,
	input  logic signed [DATA_WIDTH-1:0] meas_vel,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] drive_torque,
	output logic                         clamped,
	output logic                         traj_done,
	output logic                         done
);

	localparam int DW   = DATA_WIDTH;
	localparam int EXT  = (DW > CFG_W) ? DW : CFG_W;
	localparam int LPW  = DW + FRAC_W + 2;
	localparam int PW   = EXT + GAIN_W + 2;
	localparam int SUMW = PW + 2;
	localparam logic signed [LPW-1:0]  LERP_RND = LPW'(1) <<< (FRAC_SHIFT - 1);
	localparam logic signed [PW:0]     PD_RND   = (PW+1)'(1) <<< (PD_SHIFT - 1);
	localparam logic [32:0]            MAXV     = (33'd1 << (DW - 1)) - 33'd1;

	function automatic logic signed [DW:0] lerp_f(
		input logic signed [DW-1:0] a,
		input logic signed [DW:0]   d,
		input logic [FRAC_W-1:0]    f
	);
		logic signed [LPW-1:0] p;
		logic signed [LPW-1:0] r;
		p = LPW'(d) * LPW'($signed({1'b0, f}));
		r = (p + LERP_RND) >>> FRAC_SHIFT;
		return $signed({a[DW-1], a}) + r[DW:0];
	endfunction

	logic signed [DW-1:0] pos_a, vel_a, tq_a, pos_b, vel_b, tq_b;
	logic [31:0]          fprod;

	assign pos_a = rd_data_a[3*DW-1:2*DW];
	assign vel_a = rd_data_a[2*DW-1:DW];
	assign tq_a  = rd_data_a[DW-1:0];
	assign pos_b = rd_data_b[3*DW-1:2*DW];
	assign vel_b = rd_data_b[2*DW-1:DW];
	assign tq_b  = rd_data_b[DW-1:0];
	assign fprod = 32'(tick.phase) * 32'(inv_ticks_per_knot);

	// stage 1: fraction and knot deltas
	logic                 valid_s1, fin_s1;
	logic [FRAC_W-1:0]    f_s1;
	logic signed [DW-1:0] pa_s1, va_s1, ta_s1;
	logic signed [DW:0]   pd_s1, vd_s1, td_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid) begin
			fin_s1 <= tick.finished;
			f_s1   <= (fprod > 32'(FRAC_ONE)) ? FRAC_ONE : fprod[FRAC_W-1:0];
			pa_s1  <= pos_a;
			va_s1  <= vel_a;
			ta_s1  <= tq_a;
			pd_s1  <= tick.last ? '0 : (DW+1)'(pos_b) - (DW+1)'(pos_a);
			vd_s1  <= tick.last ? '0 : (DW+1)'(vel_b) - (DW+1)'(vel_a);
			td_s1  <= tick.last ? '0 : (DW+1)'(tq_b) - (DW+1)'(tq_a);
		end
	end

	// stage 2: interpolated targets
	logic                  valid_s2, fin_s2;
	logic signed [EXT-1:0] qd_s2;
	logic signed [DW-1:0]  vd_s2, ff_s2;
	logic signed [DW:0]    q_lerp, v_lerp, t_lerp;

	assign q_lerp = lerp_f(pa_s1, pd_s1, f_s1);
	assign v_lerp = lerp_f(va_s1, vd_s1, f_s1);
	assign t_lerp = lerp_f(ta_s1, td_s1, f_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fin_s2 <= fin_s1;
			qd_s2  <= fin_s1 ? EXT'(final_theta) : EXT'(q_lerp);
			vd_s2  <= fin_s1 ? '0 : v_lerp[DW-1:0];
			ff_s2  <= fin_s1 ? '0 : t_lerp[DW-1:0];
		end
	end

	// stage 3: gain products
	logic                   valid_s3, fin_s3;
	logic signed [PW-1:0]   pp_s3, vp_s3;
	logic signed [DW-1:0]   ff_s3;
	logic signed [EXT:0]    pos_err;
	logic signed [DW:0]     vel_err;

	assign pos_err = (EXT+1)'(qd_s2) - (EXT+1)'(meas_pos);
	assign vel_err = (DW+1)'(vd_s2) - (DW+1)'(meas_vel);

	// stage 3 to output
	logic                    out_valid_q, clamped_q, done_q;
	logic signed [DW-1:0]    drive_q;
	logic                    load_out;
	logic signed [PW:0]      pd_sum, pd_shift;
	logic signed [SUMW-1:0]  total, lim_s, lim_n;
	logic [32:0]             lim33;

	assign load_out = valid_s3 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (valid_s2) begin
			valid_s3 <= 1'b1;
		end else if (load_out) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			fin_s3 <= fin_s2;
			ff_s3  <= ff_s2;
			pp_s3  <= PW'($signed({1'b0, pos_gain})) * PW'(pos_err);
			vp_s3  <= PW'($signed({1'b0, vel_gain})) * PW'(vel_err);
		end
	end

	assign pd_sum   = (PW+1)'(pp_s3) + (PW+1)'(vp_s3) + PD_RND;
	assign pd_shift = pd_sum >>> PD_SHIFT;
	assign total    = SUMW'(ff_s3) + SUMW'(pd_shift);
	assign lim33    = ({10'd0, torque_limit} > MAXV) ? MAXV : {10'd0, torque_limit};
	assign lim_s    = $signed({{(SUMW-33){1'b0}}, lim33});
	assign lim_n    = -lim_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= load_out;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			traj_done <= fin_s3;
			if (total > lim_s) begin
				drive_q   <= lim_s[DW-1:0];
				clamped_q <= 1'b1;
			end else if (total < lim_n) begin
				drive_q   <= lim_n[DW-1:0];
				clamped_q <= 1'b1;
			end else begin
				drive_q   <= total[DW-1:0];
				clamped_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_torque = drive_q;
	assign clamped      = clamped_q;
	assign done         = load_out && !done_q;

endmodule

// ===== rtl/core/trajectory_tracking_pd_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_tracking_pd_controller
// Tick: word accepted while in_stall is low; knot read, fraction, interpolate,
// gain multiply, sum and clamp follow as registered steps. in_stall stays high
// until the result is loaded, so a new word waits for the last; out_stall holds it.
// Load: writes the knot memory, gives no result; also held off by in_stall.
// Reset clears time state and loads register defaults; knot memory is undefined
// until loaded.
// ----------------------------------------------------------------------------
module trajectory_tracking_pd_controller
	import tpc_pkg::*;
#(
	parameter int MAX_KNOTS  = 64,
	parameter int DATA_WIDTH = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [5:0]                   knot_index,
	input  logic signed [DATA_WIDTH-1:0] knot_pos,
	input  logic signed [DATA_WIDTH-1:0] knot_vel,
	input  logic signed [DATA_WIDTH-1:0] knot_torque,
	input  logic signed [DATA_WIDTH-1:0] meas_pos,
	input  logic signed [DATA_WIDTH-1:0] meas_vel,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] drive_torque,
	output logic                         clamped,
	output logic                         traj_done
);

	localparam int AW = $clog2(MAX_KNOTS);

	logic [NKNOT_W-1:0]    num_knots_q;
	logic [PHASE_W-1:0]    tpk_q, inv_q;
	logic [GAIN_W-1:0]     kp_q, kd_q;
	logic signed [CFG_W-1:0] theta_q;
	logic [LIMIT_W-1:0]    limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_knots_q <= RST_NUM_KNOTS;
			tpk_q       <= RST_TICKS_PER;
			inv_q       <= RST_INV_TICKS;
			kp_q        <= RST_POS_GAIN;
			kd_q        <= RST_VEL_GAIN;
			theta_q     <= RST_FINAL_THETA;
			limit_q     <= RST_TORQUE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_KNOTS:    num_knots_q <= cfg_data[NKNOT_W-1:0];
				REG_TICKS_PER:    tpk_q       <= cfg_data[PHASE_W-1:0];
				REG_INV_TICKS:    inv_q       <= cfg_data[PHASE_W-1:0];
				REG_POS_GAIN:     kp_q        <= cfg_data[GAIN_W-1:0];
				REG_VEL_GAIN:     kd_q        <= cfg_data[GAIN_W-1:0];
				REG_FINAL_THETA:  theta_q     <= cfg_data;
				REG_TORQUE_LIMIT: limit_q     <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	logic accept, go, wr_en, busy_q, done;
	logic [AW-1:0] rd_addr_a, rd_addr_b;
	logic [3*DATA_WIDTH-1:0] rd_data_a, rd_data_b;
	logic signed [DATA_WIDTH-1:0] meas_pos_q, meas_vel_q;
	tpc_tick_t tick;

	assign in_stall = busy_q;
	assign accept   = in_valid && !in_stall;
	assign go       = accept && (cmd == CMD_TICK);
	assign wr_en    = accept && (cmd == CMD_LOAD) && (32'(knot_index) < MAX_KNOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (go) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			meas_pos_q <= meas_pos;
			meas_vel_q <= meas_vel;
		end
	end

	tpc_knot_mem #(
		.DEPTH  (MAX_KNOTS),
		.WORD_W (3*DATA_WIDTH)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (AW'(knot_index)),
		.wr_data   ({knot_pos, knot_vel, knot_torque}),
		.rd_en     (go),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	tpc_timebase #(
		.MAX_KNOTS (MAX_KNOTS)
	) u_time (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (go),
		.num_knots      (num_knots_q),
		.ticks_per_knot (tpk_q),
		.rd_addr_a      (rd_addr_a),
		.rd_addr_b      (rd_addr_b),
		.tick           (tick)
	);

	tpc_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.tick               (tick),
		.rd_data_a          (rd_data_a),
		.rd_data_b          (rd_data_b),
		.inv_ticks_per_knot (inv_q),
		.pos_gain           (kp_q),
		.vel_gain           (kd_q),
		.final_theta        (theta_q),
		.torque_limit       (limit_q),
		.meas_pos           (meas_pos_q),
		.meas_vel           (meas_vel_q),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.drive_torque       (drive_torque),
		.clamped            (clamped),
		.traj_done          (traj_done),
		.done               (done)
	);

endmodule
